// File: design/nwc_pkg.sv
`default_nettype none
package nwc_pkg;

  localparam int DictWordsDef = 1024;
  localparam int WordLenDef   = 32;

  // configuration register indexes (byte address bit 2)
  localparam logic RegMaxEdit    = 1'b0;
  localparam logic RegShortLimit = 1'b1;

  typedef enum logic [2:0] {
    ST_UNCHANGED = 3'd0,
    ST_KNOWN     = 3'd1,
    ST_REPLACED  = 3'd2,
    ST_ADDED     = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_FULL      = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_e;

  typedef struct packed {
    logic kind;
    logic too_long;
    logic non_letter;
  } job_t;

  function automatic logic nwc_is_letter(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic [7:0] nwc_lower(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction

endpackage
`default_nettype wire

// File: design/nwc_if.sv
`default_nettype none
interface nwc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, kind, char_code, last, input ready);
  modport sink (input valid, kind, char_code, last, output ready);
endinterface

interface nwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  logic [2:0] status;

  modport source (output valid, out_char, out_last, status, input ready);
  modport sink (input valid, out_char, out_last, status, output ready);
endinterface
`default_nettype wire

// File: design/nwc_queue.sv
`default_nettype none
module nwc_queue import nwc_pkg::*; #(
  parameter int WORD_LEN = WordLenDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push_i,
  input  wire job_t                              push_job_i,
  input  wire logic [$clog2(WORD_LEN+1)-1:0]     push_len_i,
  input  wire logic [WORD_LEN-2:0][7:0]          push_chars_i,
  output logic                                   full_o,
  output logic                                   head_valid_o,
  output job_t                                   head_job_o,
  output logic [$clog2(WORD_LEN+1)-1:0]          head_len_o,
  output logic [WORD_LEN-2:0][7:0]               head_chars_o,
  input  wire logic                              pop_i
);
  localparam int LCW = $clog2(WORD_LEN + 1);

  job_t                       job_q   [2];
  logic [LCW-1:0]             len_q   [2];
  logic [WORD_LEN-2:0][7:0]   chars_q [2];
  logic                       wr_q, rd_q;
  logic [1:0]                 fill_q;

  assign full_o       = fill_q[1];
  assign head_valid_o = fill_q != 2'd0;
  assign head_job_o   = job_q[rd_q];
  assign head_len_o   = len_q[rd_q];
  assign head_chars_o = chars_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) fill_q <= fill_q + 2'd1;
      else if (!push_i && pop_i) fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      job_q[wr_q]   <= push_job_i;
      len_q[wr_q]   <= push_len_i;
      chars_q[wr_q] <= push_chars_i;
    end
  end
endmodule
`default_nettype wire

// File: design/nwc_front.sv
`default_nettype none
module nwc_front import nwc_pkg::*; #(
  parameter int WORD_LEN = WordLenDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  nwc_in_if.sink                             in_i,
  input  wire logic                          full_i,
  output logic                               push_o,
  output job_t                               push_job_o,
  output logic [$clog2(WORD_LEN+1)-1:0]      push_len_o,
  output logic [WORD_LEN-2:0][7:0]           push_chars_o
);
  localparam int LCW = $clog2(WORD_LEN + 1);
  localparam int LW  = $clog2(WORD_LEN);

  logic [WORD_LEN-2:0][7:0] wbuf_q;
  logic [LCW-1:0]           wlen_q, wlen_d;
  logic                     nl_q;
  logic                     acc, room;

  assign in_i.ready = ~full_i;
  assign acc        = in_i.valid & ~full_i;
  assign room       = wlen_q < LCW'(WORD_LEN - 1);
  assign wlen_d     = room ? wlen_q + 1'b1 : LCW'(WORD_LEN);

  always_comb begin
    push_chars_o = wbuf_q;
    if (room) push_chars_o[wlen_q[LW-1:0]] = in_i.char_code;
  end

  assign push_o              = acc & in_i.last;
  assign push_job_o.kind     = in_i.kind;
  assign push_job_o.too_long = ~room;
  assign push_job_o.non_letter = nl_q | ~nwc_is_letter(in_i.char_code);
  assign push_len_o          = room ? wlen_d : LCW'(WORD_LEN - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= '0;
      nl_q   <= 1'b0;
    end else if (acc) begin
      if (in_i.last) begin
        wlen_q <= '0;
        nl_q   <= 1'b0;
      end else begin
        wlen_q <= wlen_d;
        nl_q   <= nl_q | ~nwc_is_letter(in_i.char_code);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && room) wbuf_q[wlen_q[LW-1:0]] <= in_i.char_code;
  end
endmodule
`default_nettype wire

// File: design/nwc_back.sv
`default_nettype none
module nwc_back import nwc_pkg::*; #(
  parameter int DICT_WORDS = DictWordsDef,
  parameter int WORD_LEN   = WordLenDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [1:0]                    max_edit_i,
  input  wire logic [4:0]                    short_limit_i,
  input  wire logic                          head_valid_i,
  input  wire job_t                          head_job_i,
  input  wire logic [$clog2(WORD_LEN+1)-1:0] head_len_i,
  input  wire logic [WORD_LEN-2:0][7:0]      head_chars_i,
  output logic                               pop_o,
  nwc_out_if.source                          out_o
);
  localparam int LCW   = $clog2(WORD_LEN + 1);
  localparam int LW    = $clog2(WORD_LEN);
  localparam int EW    = $clog2(DICT_WORDS);
  localparam int CW    = $clog2(DICT_WORDS + 1);
  localparam int NCH   = WORD_LEN - 1;
  localparam int CHDEP = DICT_WORDS << LW;

  typedef enum logic [3:0] {
    S_IDLE, S_LEN, S_LCHK, S_FETCH, S_FWAIT, S_EVAL, S_DP, S_DCMP, S_RES, S_ADD, S_EMIT
  } state_e;

  typedef enum logic [1:0] {SRC_STAT, SRC_RAW, SRC_BEST} src_e;

  state_e         state_q;
  src_e           src_q;
  status_e        est_q;
  logic           dup_q, found_q, fv_q, ov_q, olast_q;
  logic [CW-1:0]  count_q, e_q;
  logic [LCW-1:0] k_q, fk_q, elen_q, bestlen_q, best_q, d_q, i_q, j_q, diag_q, left_q;
  logic [7:0]     och_q;
  status_e        ost_q;

  logic [7:0]     ebuf_q [NCH];
  logic [7:0]     bestbuf_q [NCH];
  logic [LCW-1:0] row_q [NCH];

  logic [7:0]     dchar_mem [CHDEP];
  logic [LCW-1:0] dlen_mem [DICT_WORDS];
  logic [7:0]     rdc_q;
  logic [LCW-1:0] rdl_q;

  logic [7:0]     lw [NCH];
  logic           eq, skip, slot_free, em_last, add_we, best_upd;
  logic [LCW-1:0] diff, n, dp_cell, up, ins_c, del_c, sub_c;
  logic [7:0]     em_char;

  assign n = head_len_i;

  always_comb begin
    for (int k = 0; k < NCH; k++) lw[k] = nwc_lower(head_chars_i[k]);
  end

  always_comb begin
    eq = (elen_q == n);
    for (int k = 0; k < NCH; k++) begin
      if (LCW'(k) < n && ebuf_q[k] != lw[k]) eq = 1'b0;
    end
  end

  assign diff = (rdl_q > n) ? rdl_q - n : n - rdl_q;
  assign skip = dup_q ? (rdl_q != n) : (diff > LCW'(max_edit_i));

  // one table entry per cycle; the row is updated in place
  assign up    = row_q[LW'(j_q - 1'b1)];
  assign del_c = up + 1'b1;
  assign ins_c = left_q + 1'b1;
  assign sub_c = diag_q + LCW'(lw[LW'(i_q - 1'b1)] != ebuf_q[LW'(j_q - 1'b1)]);
  always_comb begin
    dp_cell = (del_c < ins_c) ? del_c : ins_c;
    if (sub_c < dp_cell) dp_cell = sub_c;
  end

  assign best_upd = ((state_q == S_EVAL) && !dup_q && eq) ||
                    ((state_q == S_DCMP) && (d_q < best_q));

  assign slot_free = ~ov_q | out_o.ready;
  always_comb begin
    case (src_q)
      SRC_RAW: begin
        em_char = head_chars_i[k_q[LW-1:0]];
        em_last = (k_q == n - 1'b1);
      end
      SRC_BEST: begin
        em_char = bestbuf_q[k_q[LW-1:0]];
        em_last = (k_q == bestlen_q - 1'b1);
      end
      default: begin
        em_char = 8'd0;
        em_last = 1'b1;
      end
    endcase
  end
  assign pop_o  = (state_q == S_EMIT) && slot_free && em_last;
  assign add_we = (state_q == S_ADD);

  assign out_o.valid    = ov_q;
  assign out_o.out_char = och_q;
  assign out_o.out_last = olast_q;
  assign out_o.status   = ost_q;

  always_ff @(posedge clk_i) begin
    if (add_we) begin
      dchar_mem[{count_q[EW-1:0], k_q[LW-1:0]}] <= lw[k_q[LW-1:0]];
      if (k_q == n - 1'b1) dlen_mem[count_q[EW-1:0]] <= n;
    end
    rdc_q <= dchar_mem[{e_q[EW-1:0], k_q[LW-1:0]}];
    rdl_q <= dlen_mem[e_q[EW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (fv_q) ebuf_q[fk_q[LW-1:0]] <= rdc_q;
    if (best_upd) bestbuf_q <= ebuf_q;
    if (state_q == S_EVAL) begin
      for (int k = 0; k < NCH; k++) row_q[k] <= LCW'(k + 1);
    end else if (state_q == S_DP) begin
      row_q[LW'(j_q - 1'b1)] <= dp_cell;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      src_q     <= SRC_STAT;
      est_q     <= ST_UNCHANGED;
      dup_q     <= 1'b0;
      found_q   <= 1'b0;
      fv_q      <= 1'b0;
      ov_q      <= 1'b0;
      olast_q   <= 1'b0;
      och_q     <= 8'd0;
      ost_q     <= ST_UNCHANGED;
      count_q   <= '0;
      e_q       <= '0;
      k_q       <= '0;
      fk_q      <= '0;
      elen_q    <= '0;
      bestlen_q <= '0;
      best_q    <= '0;
      d_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      diag_q    <= '0;
      left_q    <= '0;
    end else begin
      fv_q <= (state_q == S_FETCH);
      if ((state_q == S_EMIT) && slot_free) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
      if (best_upd) bestlen_q <= elen_q;
      case (state_q)
        S_IDLE: begin
          if (head_valid_i) begin
            k_q     <= '0;
            e_q     <= '0;
            found_q <= 1'b0;
            best_q  <= LCW'(max_edit_i) + 1'b1;
            dup_q   <= ~head_job_i.kind;
            if (!head_job_i.kind) begin
              if (count_q >= CW'(DICT_WORDS)) begin
                src_q   <= SRC_STAT;
                est_q   <= ST_FULL;
                state_q <= S_EMIT;
              end else begin
                state_q <= S_LEN;
              end
            end else if (head_job_i.too_long) begin
              src_q   <= SRC_STAT;
              est_q   <= ST_TOO_LONG;
              state_q <= S_EMIT;
            end else if (head_job_i.non_letter || 8'(n) <= 8'(short_limit_i)) begin
              src_q   <= SRC_RAW;
              est_q   <= ST_UNCHANGED;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_LEN;
            end
          end
        end
        S_LEN: begin
          if (e_q == count_q) begin
            k_q     <= '0;
            state_q <= dup_q ? S_ADD : S_RES;
          end else begin
            state_q <= S_LCHK;
          end
        end
        S_LCHK: begin
          if (skip) begin
            e_q     <= e_q + 1'b1;
            state_q <= S_LEN;
          end else begin
            elen_q  <= rdl_q;
            k_q     <= '0;
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          fk_q <= k_q;
          if (k_q == elen_q - 1'b1) state_q <= S_FWAIT;
          else k_q <= k_q + 1'b1;
        end
        S_FWAIT: state_q <= S_EVAL;
        S_EVAL: begin
          if (dup_q) begin
            if (eq) begin
              src_q   <= SRC_STAT;
              est_q   <= ST_DUPLICATE;
              k_q     <= '0;
              state_q <= S_EMIT;
            end else begin
              e_q     <= e_q + 1'b1;
              state_q <= S_LEN;
            end
          end else if (eq) begin
            // exact match: nothing can beat it
            best_q  <= '0;
            found_q <= 1'b1;
            state_q <= S_RES;
          end else begin
            i_q     <= LCW'(1);
            j_q     <= LCW'(1);
            diag_q  <= '0;
            left_q  <= LCW'(1);
            state_q <= S_DP;
          end
        end
        S_DP: begin
          if (j_q == elen_q) begin
            if (i_q == n) begin
              d_q     <= dp_cell;
              state_q <= S_DCMP;
            end else begin
              diag_q <= i_q;
              left_q <= i_q + 1'b1;
              i_q    <= i_q + 1'b1;
              j_q    <= LCW'(1);
            end
          end else begin
            diag_q <= up;
            left_q <= dp_cell;
            j_q    <= j_q + 1'b1;
          end
        end
        S_DCMP: begin
          if (d_q < best_q) begin
            best_q  <= d_q;
            found_q <= 1'b1;
          end
          e_q     <= e_q + 1'b1;
          state_q <= S_LEN;
        end
        S_RES: begin
          k_q <= '0;
          if (found_q && best_q == '0) begin
            src_q <= SRC_RAW;
            est_q <= ST_KNOWN;
          end else if (found_q) begin
            src_q <= SRC_BEST;
            est_q <= ST_REPLACED;
          end else begin
            src_q <= SRC_RAW;
            est_q <= ST_UNCHANGED;
          end
          state_q <= S_EMIT;
        end
        S_ADD: begin
          if (k_q == n - 1'b1) begin
            count_q <= count_q + 1'b1;
            k_q     <= '0;
            src_q   <= SRC_STAT;
            est_q   <= ST_ADDED;
            state_q <= S_EMIT;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            och_q   <= em_char;
            olast_q <= em_last;
            ost_q   <= est_q;
            if (em_last) state_q <= S_IDLE;
            else k_q <= k_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/nearest_dictionary_word_corrector.sv
`default_nettype none
// channel   dir  handshake      payload
// in_i      in   valid/ready    kind, char_code, last
// out_o     out  valid/ready    out_char, out_last, status
// apb       in   psel/penable   paddr, pwdata, prdata (reg 0 max edit, reg 4 short limit)
//
// A character that does not end a word is taken unless the queue (two finished words) is
// full. A query scan checks each entry's length; each within the length window is fetched,
// awaited, evaluated and, unless an exact match, scored by the edit table and compared. A load
// scan fetches and compares entries of equal length, then writes the word. Results leave at
// one per cycle from an output register as out_o.ready allows. No clearing pass after reset.
module nearest_dictionary_word_corrector import nwc_pkg::*; #(
  parameter int DICT_WORDS = DictWordsDef,
  parameter int WORD_LEN   = WordLenDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  nwc_in_if.sink           in_i,
  nwc_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int LCW = $clog2(WORD_LEN + 1);

  logic [1:0]               max_edit_q;
  logic [4:0]               short_q;
  logic                     full, push, head_valid, pop;
  job_t                     push_job, head_job;
  logic [LCW-1:0]           push_len, head_len;
  logic [WORD_LEN-2:0][7:0] push_chars, head_chars;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegShortLimit) ? {27'd0, short_q} : {30'd0, max_edit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_edit_q <= 2'd1;
      short_q    <= 5'd3;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegMaxEdit) max_edit_q <= pwdata[1:0];
      else short_q <= pwdata[4:0];
    end
  end

  nwc_front #(.WORD_LEN(WORD_LEN)) u_front (
    .clk_i, .rst_ni, .in_i, .full_i(full), .push_o(push), .push_job_o(push_job),
    .push_len_o(push_len), .push_chars_o(push_chars)
  );

  nwc_queue #(.WORD_LEN(WORD_LEN)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_job_i(push_job), .push_len_i(push_len),
    .push_chars_i(push_chars), .full_o(full), .head_valid_o(head_valid),
    .head_job_o(head_job), .head_len_o(head_len), .head_chars_o(head_chars), .pop_i(pop)
  );

  nwc_back #(.DICT_WORDS(DICT_WORDS), .WORD_LEN(WORD_LEN)) u_back (
    .clk_i, .rst_ni, .max_edit_i(max_edit_q), .short_limit_i(short_q),
    .head_valid_i(head_valid), .head_job_i(head_job), .head_len_i(head_len),
    .head_chars_i(head_chars), .pop_o(pop), .out_o
  );
endmodule
`default_nettype wire
